FILE: hdl/mkdb_pkg.sv
package mkdb_pkg;

    localparam int KEY_COUNT = 7;
    localparam int KEY_W     = 3;
    localparam int SLOT_CNT  = 2 * KEY_COUNT;
    localparam int SLOT_W    = KEY_W + 1;
    localparam int DB_W      = 4;
    localparam int HOLD_W    = 10;
    localparam int CFG_W     = 10;

    localparam logic [DB_W-1:0]   DEBOUNCE_RESET   = 4'd3;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 10'd100;
    localparam logic [HOLD_W-1:0] HOLD_MAX         = 10'd1023;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_CLICK    = 2'd1,
        EV_RELEASED = 2'd2,
        EV_LONG     = 2'd3
    } t_event;

    typedef enum logic {
        CFG_DEBOUNCE   = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0] valid;
        t_event     code0;
        t_event     code1;
    } t_key_ev;

endpackage

FILE: hdl/mkdb_key.sv
module mkdb_key (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic                          i_level,
    input  logic [mkdb_pkg::DB_W-1:0]     i_debounce_ticks,
    input  logic [mkdb_pkg::HOLD_W-1:0]   i_long_press_ticks,
    output logic                          o_stable_next,
    output mkdb_pkg::t_key_ev             o_ev
);
    import mkdb_pkg::*;

    logic              r_prev;
    logic              r_stable;
    logic [DB_W-1:0]   r_run;
    logic [HOLD_W-1:0] r_hold;
    logic              r_long_rep;

    logic              n_stable;
    logic [DB_W-1:0]   n_run;
    logic [HOLD_W-1:0] n_hold;
    logic              n_long_rep;

    logic              same;
    logic              take_level;
    logic              press;
    logic              release_ev;
    logic              click;
    logic              long_ev;
    logic              long_mid;
    logic [HOLD_W-1:0] hold_inc;

    always_comb begin
        hold_inc = r_hold;
        if (!r_stable && (r_hold != HOLD_MAX)) begin
            hold_inc = r_hold + HOLD_W'(1);
        end
        same = (i_level == r_prev);
        if (!same) begin
            n_run = '0;
        end else if (r_run < i_debounce_ticks) begin
            n_run = r_run + DB_W'(1);
        end else begin
            n_run = r_run;
        end
        take_level = same && (n_run >= i_debounce_ticks);
        n_stable   = take_level ? i_level : r_stable;
        press      = take_level && r_stable && !i_level;
        release_ev = take_level && !r_stable && i_level;
        n_hold     = press ? '0 : hold_inc;
        long_mid   = press ? 1'b0 : r_long_rep;
        long_ev    = !n_stable && !long_mid && (n_hold >= i_long_press_ticks);
        n_long_rep = long_ev ? 1'b1 : long_mid;
        click      = release_ev && (hold_inc < i_long_press_ticks);
    end

    always_comb begin
        o_ev.valid = 2'b00;
        o_ev.code0 = EV_PRESSED;
        o_ev.code1 = EV_LONG;
        if (press) begin
            o_ev.valid = {long_ev, 1'b1};
        end else if (release_ev) begin
            if (click) begin
                o_ev.valid = 2'b11;
                o_ev.code0 = EV_CLICK;
                o_ev.code1 = EV_RELEASED;
            end else begin
                o_ev.valid = 2'b01;
                o_ev.code0 = EV_RELEASED;
            end
        end else if (long_ev) begin
            o_ev.valid = 2'b01;
            o_ev.code0 = EV_LONG;
        end
    end

    assign o_stable_next = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= 1'b1;
            r_stable   <= 1'b1;
            r_run      <= '0;
            r_hold     <= '0;
            r_long_rep <= 1'b0;
        end else if (i_tick) begin
            r_prev     <= i_level;
            r_stable   <= n_stable;
            r_run      <= n_run;
            r_hold     <= n_hold;
            r_long_rep <= n_long_rep;
        end
    end

endmodule

FILE: hdl/multi_key_debounce_click_long_press_unit.sv
// Debouncer for a bank of active-low keys with click and long-press events.
// Each input beat on i_valid/o_stall is one scan tick carrying the raw pin
// levels of all keys. The tick updates the per-key debounce and hold state in
// the cycle it is accepted and turns into zero to two events per key.
// Events leave on o_valid/i_stall one beat per cycle, in key order, each with
// the key index, the event code, the debounced levels after the tick and a
// flag on the last event of that tick. A tick without events gives no beat.
// Events go through the current-tick register, after the pending one if a
// tick is still draining, then the output register. One tick is draining
// while one more waits, and o_stall is high while a tick waits. Any tick,
// with or without events, is taken back to back otherwise. When the receiver
// stalls, the output beat holds and draining pauses. Reset returns every key
// to released with cleared counters, and restores the debounce and long-press
// registers to 3 and 100 ticks. The user must write them through i_cfg_we,
// i_cfg_index and i_cfg_data only while idle; the block does not enforce it.
module multi_key_debounce_click_long_press_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mkdb_pkg::KEY_COUNT-1:0]      i_raw_levels,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mkdb_pkg::KEY_W-1:0]          o_key_index,
    output logic [1:0]                          o_event_code,
    output logic [mkdb_pkg::KEY_COUNT-1:0]      o_stable_levels,
    output logic                                o_last_of_run,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [mkdb_pkg::CFG_W-1:0]          i_cfg_data
);
    import mkdb_pkg::*;

    logic [DB_W-1:0]   r_debounce;
    logic [HOLD_W-1:0] r_long_press;

    t_key_ev              key_ev [KEY_COUNT];
    logic [KEY_COUNT-1:0] stable_next;
    logic [SLOT_CNT-1:0]  new_mask;
    t_event               new_codes [SLOT_CNT];
    logic                 accept;

    logic                 r_pend_valid;
    logic [SLOT_CNT-1:0]  r_pend_mask;
    t_event               r_pend_codes [SLOT_CNT];
    logic [KEY_COUNT-1:0] r_pend_stable;

    logic [SLOT_CNT-1:0]  r_cur_mask;
    t_event               r_cur_codes [SLOT_CNT];
    logic [KEY_COUNT-1:0] r_cur_stable;

    logic                 r_out_valid;
    logic [KEY_W-1:0]     r_out_key;
    t_event               r_out_code;
    logic [KEY_COUNT-1:0] r_out_stable;
    logic                 r_out_last;

    logic                 out_free;
    logic                 emit;
    logic [SLOT_CNT-1:0]  rest_mask;
    logic [SLOT_W-1:0]    sel;
    logic                 cur_free;
    logic                 pend_move;
    logic                 load_cur_direct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RESET;
            r_long_press <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[DB_W-1:0];
                CFG_LONG_PRESS: r_long_press <= i_cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_stall = r_pend_valid;
    assign accept  = i_valid && !r_pend_valid;

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        mkdb_key u_key (
            .i_clk              (i_clk),
            .i_rst_n            (i_rst_n),
            .i_tick             (accept),
            .i_level            (i_raw_levels[k]),
            .i_debounce_ticks   (r_debounce),
            .i_long_press_ticks (r_long_press),
            .o_stable_next      (stable_next[k]),
            .o_ev               (key_ev[k])
        );

        assign new_mask[2*k]     = key_ev[k].valid[0];
        assign new_mask[2*k+1]   = key_ev[k].valid[1];
        assign new_codes[2*k]    = key_ev[k].code0;
        assign new_codes[2*k+1]  = key_ev[k].code1;
    end

    always_comb begin
        sel = '0;
        for (int j = SLOT_CNT - 1; j >= 0; j--) begin
            if (r_cur_mask[j]) begin
                sel = SLOT_W'(j);
            end
        end
    end

    assign out_free        = !r_out_valid || !i_stall;
    assign emit            = (r_cur_mask != '0) && out_free;
    assign rest_mask       = r_cur_mask & (r_cur_mask - SLOT_CNT'(1));
    assign cur_free        = (r_cur_mask == '0) || (emit && (rest_mask == '0));
    assign pend_move       = r_pend_valid && cur_free;
    assign load_cur_direct = accept && (new_mask != '0) && cur_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (pend_move) begin
            r_pend_valid <= 1'b0;
        end else if (accept && (new_mask != '0) && !cur_free) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_mask   <= new_mask;
            r_pend_codes  <= new_codes;
            r_pend_stable <= stable_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mask <= '0;
        end else if (pend_move) begin
            r_cur_mask <= r_pend_mask;
        end else if (load_cur_direct) begin
            r_cur_mask <= new_mask;
        end else if (emit) begin
            r_cur_mask <= rest_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_cur_codes  <= r_pend_codes;
            r_cur_stable <= r_pend_stable;
        end else if (load_cur_direct) begin
            r_cur_codes  <= new_codes;
            r_cur_stable <= stable_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_key    <= sel[SLOT_W-1:1];
            r_out_code   <= r_cur_codes[sel];
            r_out_stable <= r_cur_stable;
            r_out_last   <= (rest_mask == '0);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_key_index     = r_out_key;
    assign o_event_code    = r_out_code;
    assign o_stable_levels = r_out_stable;
    assign o_last_of_run   = r_out_last;

endmodule
